// ===== src/benes_permute_128_assert.svh =====
// ----------------------------------------------------------------------------
// benes_permute_128_assert.svh
// Assertion macros for the Benes permutation block.
// ----------------------------------------------------------------------------
`ifndef BENES_PERMUTE_128_ASSERT_SVH
`define BENES_PERMUTE_128_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BP_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BP_ASSERT(label, clk, rst_n, prop, msg)
`define BP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== src/bp128_pkg.sv =====
// ----------------------------------------------------------------------------
// bp128_pkg
// Types, constants and wiring functions of the 128-bit Benes network.
// ----------------------------------------------------------------------------
`default_nettype none
package bp128_pkg;

  localparam int NET_WIDTH    = 128;
  localparam int NET_STAGES   = 13;
  localparam int NET_SWITCHES = 64;
  localparam int CTRL_WORDS   = 26;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PERMUTE = 1'b1
  } opcode_t;

  typedef logic [NET_WIDTH-1:0]    vec_t;
  typedef logic [NET_SWITCHES-1:0] col_t;

  function automatic vec_t switch_col(input vec_t x, input col_t sel);
    vec_t y;
    logic [6:0] j;
    for (int i = 0; i < NET_WIDTH; i++) begin
      j    = 7'(i);
      y[i] = sel[j[6:1]] ? x[j ^ 7'd1] : x[j];
    end
    return y;
  endfunction

  // split each block of 2^lg lines into even lines then odd lines
  function automatic vec_t unshuffle(input vec_t x, input int lg);
    vec_t y;
    logic [6:0] j, msk, off, src, half;
    msk  = 7'((1 << lg) - 1);
    half = 7'(1 << (lg - 1));
    for (int i = 0; i < NET_WIDTH; i++) begin
      j   = 7'(i);
      off = j & msk;
      if (off < half) src = (j & ~msk) | (off << 1);
      else            src = (j & ~msk) | ((off - half) << 1) | 7'd1;
      y[i] = x[src];
    end
    return y;
  endfunction

  // interleave the two halves of each block of 2^lg lines
  function automatic vec_t shuffle(input vec_t x, input int lg);
    vec_t y;
    logic [6:0] j, msk, off, src, half;
    msk  = 7'((1 << lg) - 1);
    half = 7'(1 << (lg - 1));
    for (int i = 0; i < NET_WIDTH; i++) begin
      j    = 7'(i);
      off  = j & msk;
      src  = (j & ~msk) | (off >> 1) | (off[0] ? half : 7'd0);
      y[i] = x[src];
    end
    return y;
  endfunction

  function automatic vec_t stage_wire(input vec_t x, input int k);
    if (k < 6)       return unshuffle(x, 7 - k);
    else if (k < 12) return shuffle(x, k - 4);
    else             return x;
  endfunction

endpackage
`default_nettype wire

// ===== src/bp128_if.sv =====
// ----------------------------------------------------------------------------
// bp128_in_if / bp128_out_if
// Handshake channels of the Benes permutation block.
// ----------------------------------------------------------------------------
`default_nettype none
interface bp128_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [4:0]  word_index;
  logic [31:0] control_value;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;
  modport source (output valid, opcode, word_index, control_value,
                  word_a, word_b, word_c, word_d, input ready);
  modport sink   (input valid, opcode, word_index, control_value,
                  word_a, word_b, word_c, word_d, output ready);
endinterface

interface bp128_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic [31:0] out_c;
  logic [31:0] out_d;
  modport source (output valid, out_a, out_b, out_c, out_d, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, output ready);
endinterface
`default_nettype wire

// ===== src/benes_permute_128.sv =====
// ----------------------------------------------------------------------------
// benes_permute_128
// 128-bit Benes network, 13 switch columns, one register stage per column.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   opcode, word_index, control_value, word_a..word_d
//  out_ch    out  out_a..out_d (permute transfers only)
//
//  One transfer per cycle in unless out_ch stalls; one register stage per switch column.
//  Loads travel the pipe and update each column's switch bits as they pass,
//  so every item sees exactly the loads that came before it.
//  Reset clears all switch bits (identity routing) and the valid bits.
//  A stall on out_ch freezes the whole pipe; nothing is dropped or repeated.
`default_nettype none
`include "benes_permute_128_assert.svh"
module benes_permute_128 (
  input  wire logic     clk,
  input  wire logic     rst_n,
  bp128_in_if.sink      in_ch,
  bp128_out_if.source   out_ch
);

  localparam int NS = bp128_pkg::NET_STAGES;

  logic                 adv;
  logic [NS-1:0]        v_r;
  logic                 op_r   [NS];
  logic [4:0]           idx_r  [NS];
  logic [31:0]          val_r  [NS];
  bp128_pkg::vec_t      dat_r  [NS];
  bp128_pkg::col_t      ctrl_r [NS];

  logic                 p_v    [NS];
  logic                 p_op   [NS];
  logic [4:0]           p_idx  [NS];
  logic [31:0]          p_val  [NS];
  bp128_pkg::vec_t      p_dat  [NS];

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  assign p_v[0]   = in_ch.valid;
  assign p_op[0]  = in_ch.opcode;
  assign p_idx[0] = in_ch.word_index;
  assign p_val[0] = in_ch.control_value;
  assign p_dat[0] = {in_ch.word_d, in_ch.word_c, in_ch.word_b, in_ch.word_a};

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign p_v[k]   = v_r[k-1];
      assign p_op[k]  = op_r[k-1];
      assign p_idx[k] = idx_r[k-1];
      assign p_val[k] = val_r[k-1];
      assign p_dat[k] = dat_r[k-1];
    end

    logic ld_hit;
    assign ld_hit = p_v[k] && (p_op[k] == bp128_pkg::OP_LOAD)
                    && (p_idx[k][4:1] == 4'(k));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k]    <= 1'b0;
        ctrl_r[k] <= '0;
      end else if (adv) begin
        v_r[k] <= p_v[k];
        if (ld_hit) begin
          if (p_idx[k][0]) ctrl_r[k][63:32] <= p_val[k];
          else             ctrl_r[k][31:0]  <= p_val[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        op_r[k]  <= p_op[k];
        idx_r[k] <= p_idx[k];
        val_r[k] <= p_val[k];
        dat_r[k] <= bp128_pkg::stage_wire(
                      bp128_pkg::switch_col(p_dat[k], ctrl_r[k]), k);
      end
    end
  end

  assign out_ch.valid = v_r[NS-1] && (op_r[NS-1] == bp128_pkg::OP_PERMUTE);
  assign out_ch.out_a = dat_r[NS-1][31:0];
  assign out_ch.out_b = dat_r[NS-1][63:32];
  assign out_ch.out_c = dat_r[NS-1][95:64];
  assign out_ch.out_d = dat_r[NS-1][127:96];

  `BP_ASSERT(a_stall_freeze, clk, rst_n, (out_ch.valid && !out_ch.ready) |=> $stable(v_r), "pipe moved during stall")
  `BP_ASSERT(a_accept_enters, clk, rst_n, (in_ch.valid && in_ch.ready) |=> v_r[0], "transfer lost at entry")
  `BP_ASSERT(a_out_from_permute, clk, rst_n, out_ch.valid |-> (v_r[NS-1] && op_r[NS-1] == bp128_pkg::OP_PERMUTE), "load produced output")

endmodule
`default_nettype wire
